/* rtl/core/rrq_pkg.sv */
// rrq_pkg: shared types and constants of the round-robin run queue
// command codes, fsm states, memory entry layouts and the result beat
// no dependencies
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned THREAD_W   = 8;
  localparam int unsigned CPU_W      = 3;
  localparam int unsigned SLOT_OUT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PICK    = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_LOOKUP = 3'd2,
    ST_SCAN   = 3'd3,
    ST_DONE   = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_FIND = 2'd1,
    MODE_PICK = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic                valid;
    logic [THREAD_W-1:0] thread;
  } slot_ent_t;

  typedef struct packed {
    logic enq;
    logic locked;
  } thr_ent_t;

  typedef struct packed {
    logic slot;
    logic thr;
    logic last;
  } wr_en_t;

  typedef struct packed {
    logic                  ok;
    logic [THREAD_W-1:0]   thread;
    logic [SLOT_OUT_W-1:0] slot;
  } result_t;

endpackage

/* rtl/core/rrq_ifs.sv */
// rrq_ifs: command and result channel interfaces of the run queue
// valid/ready handshake, one beat per command or result
// depends on rrq_pkg
`timescale 1ns / 1ps

interface rrq_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rrq_pkg::CMD_W-1:0]    cmd;
  logic [rrq_pkg::THREAD_W-1:0] thread_id;
  logic [rrq_pkg::CPU_W-1:0]    cpu_index;

  modport source (output valid, cmd, thread_id, cpu_index, input ready);
  modport sink (input valid, cmd, thread_id, cpu_index, output ready);
endinterface

interface rrq_res_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [rrq_pkg::THREAD_W-1:0]   picked_thread;
  logic [rrq_pkg::SLOT_OUT_W-1:0] picked_slot;

  modport source (output valid, ok, picked_thread, picked_slot, input ready);
  modport sink (input valid, ok, picked_thread, picked_slot, output ready);
endinterface

/* rtl/core/rrq_mems.sv */
// rrq_mems: slot table, per-thread flag table and per-cpu last index memories
// one write and one registered read port each, plus the clearing sweep after reset
// depends on rrq_pkg
`timescale 1ns / 1ps

module rrq_mems #(
  parameter int SLOTS      = 64,
  parameter int THREAD_IDS = 256,
  parameter int CPUS       = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  clr_busy,
  input  rrq_pkg::wr_en_t                       we,
  input  logic [$clog2(SLOTS)-1:0]              slot_wa,
  input  rrq_pkg::slot_ent_t                    slot_wd,
  input  logic [$clog2(SLOTS)-1:0]              slot_ra,
  output rrq_pkg::slot_ent_t                    slot_rd,
  input  logic [$clog2(THREAD_IDS)-1:0]         thr_wa,
  input  rrq_pkg::thr_ent_t                     thr_wd,
  input  logic [$clog2(THREAD_IDS)-1:0]         thr_ra,
  output rrq_pkg::thr_ent_t                     thr_rd,
  input  logic [((CPUS > 1) ? $clog2(CPUS) : 1)-1:0] last_wa,
  input  logic [$clog2(SLOTS)-1:0]              last_wd,
  input  logic [((CPUS > 1) ? $clog2(CPUS) : 1)-1:0] last_ra,
  output logic [$clog2(SLOTS)-1:0]              last_rd
);

  localparam int SW    = $clog2(SLOTS);
  localparam int TW    = $clog2(THREAD_IDS);
  localparam int CW    = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int CLR_A = (SLOTS > THREAD_IDS) ? SLOTS : THREAD_IDS;
  localparam int CLR_N = (CLR_A > CPUS) ? CLR_A : CPUS;
  localparam int CLRW  = $clog2(CLR_N);

  rrq_pkg::slot_ent_t slot_mem [SLOTS];
  rrq_pkg::thr_ent_t  thr_mem  [THREAD_IDS];
  logic [SW-1:0]      last_mem [CPUS];

  logic [CLRW-1:0]    clr_cnt;

  logic               slot_we_eff;
  logic [SW-1:0]      slot_wa_eff;
  rrq_pkg::slot_ent_t slot_wd_eff;
  logic               thr_we_eff;
  logic [TW-1:0]      thr_wa_eff;
  rrq_pkg::thr_ent_t  thr_wd_eff;
  logic               last_we_eff;
  logic [CW-1:0]      last_wa_eff;
  logic [SW-1:0]      last_wd_eff;

  // clearing sweep, one entry of each memory per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      if (clr_cnt == CLRW'(CLR_N - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    if (clr_busy) begin
      slot_we_eff = (32'(clr_cnt) < SLOTS);
      slot_wa_eff = clr_cnt[SW-1:0];
      slot_wd_eff = '0;
      thr_we_eff  = (32'(clr_cnt) < THREAD_IDS);
      thr_wa_eff  = clr_cnt[TW-1:0];
      thr_wd_eff  = '0;
      last_we_eff = (32'(clr_cnt) < CPUS);
      last_wa_eff = CW'(clr_cnt);
      last_wd_eff = '0;
    end else begin
      slot_we_eff = we.slot;
      slot_wa_eff = slot_wa;
      slot_wd_eff = slot_wd;
      thr_we_eff  = we.thr;
      thr_wa_eff  = thr_wa;
      thr_wd_eff  = thr_wd;
      last_we_eff = we.last;
      last_wa_eff = last_wa;
      last_wd_eff = last_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we_eff) begin
      slot_mem[slot_wa_eff] <= slot_wd_eff;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (thr_we_eff) begin
      thr_mem[thr_wa_eff] <= thr_wd_eff;
    end
    thr_rd <= thr_mem[thr_ra];
  end

  always_ff @(posedge clk) begin
    if (last_we_eff) begin
      last_mem[last_wa_eff] <= last_wd_eff;
    end
    last_rd <= last_mem[last_ra];
  end

endmodule

/* rtl/core/rrq_ctrl.sv */
// rrq_ctrl: command sequencer and pipelined slot scan of the run queue
// reads, modifies and writes back the memories in rrq_mems; one command at a time
// depends on rrq_pkg and rrq_ifs
`timescale 1ns / 1ps

module rrq_ctrl #(
  parameter int SLOTS      = 64,
  parameter int THREAD_IDS = 256,
  parameter int CPUS       = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  rrq_cmd_if.sink                               req,
  input  logic                                  clr_busy,
  output rrq_pkg::wr_en_t                       we,
  output logic [$clog2(SLOTS)-1:0]              slot_wa,
  output rrq_pkg::slot_ent_t                    slot_wd,
  output logic [$clog2(SLOTS)-1:0]              slot_ra,
  input  rrq_pkg::slot_ent_t                    slot_rd,
  output logic [$clog2(THREAD_IDS)-1:0]         thr_wa,
  output rrq_pkg::thr_ent_t                     thr_wd,
  output logic [$clog2(THREAD_IDS)-1:0]         thr_ra,
  input  rrq_pkg::thr_ent_t                     thr_rd,
  output logic [((CPUS > 1) ? $clog2(CPUS) : 1)-1:0] last_wa,
  output logic [$clog2(SLOTS)-1:0]              last_wd,
  output logic [((CPUS > 1) ? $clog2(CPUS) : 1)-1:0] last_ra,
  input  logic [$clog2(SLOTS)-1:0]              last_rd,
  output logic                                  done_valid,
  input  logic                                  done_ack,
  output rrq_pkg::result_t                      res
);

  localparam int SW   = $clog2(SLOTS);
  localparam int TW   = $clog2(THREAD_IDS);
  localparam int CW   = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);

  rrq_pkg::state_t     state, state_next;
  rrq_pkg::cmd_t       cmd_r;
  rrq_pkg::scan_mode_t mode;
  logic [rrq_pkg::THREAD_W-1:0] tid_r;
  logic [TW-1:0]       thr_r;
  logic [CW-1:0]       cpu_r;
  rrq_pkg::thr_ent_t   flags_r;

  logic [SW-1:0]       scan_idx;
  logic [CNTW-1:0]     issue_cnt;
  logic                s1_vld, s1_last;
  logic [SW-1:0]       s1_idx;
  logic                s2_vld, s2_last;
  logic [SW-1:0]       s2_idx;
  rrq_pkg::slot_ent_t  s2_ent;

  logic                req_bad;
  logic                issue;
  logic                hit;
  logic                scan_end;
  logic [SW-1:0]       pick_start;
  logic                res_load;
  rrq_pkg::result_t    res_next;

  assign req_bad = (rrq_pkg::cmd_t'(req.cmd) == rrq_pkg::CMD_PICK)
                   ? (32'(req.cpu_index) >= CPUS)
                   : (32'(req.thread_id) >= THREAD_IDS);

  assign issue      = (issue_cnt < CNTW'(SLOTS));
  assign pick_start = (last_rd == SW'(SLOTS - 1)) ? '0 : last_rd + 1'b1;

  always_comb begin
    unique case (mode)
      rrq_pkg::MODE_FREE: hit = s2_vld && !s2_ent.valid;
      rrq_pkg::MODE_FIND: hit = s2_vld && s2_ent.valid && (s2_ent.thread == tid_r);
      rrq_pkg::MODE_PICK: hit = s2_vld && s2_ent.valid && !thr_rd.locked;
      default:            hit = 1'b0;
    endcase
  end

  assign scan_end   = hit || (s2_vld && s2_last);
  assign req.ready  = (state == rrq_pkg::ST_IDLE);
  assign done_valid = (state == rrq_pkg::ST_DONE);

  // read addresses
  assign slot_ra = scan_idx;
  assign last_ra = CW'(req.cpu_index);

  always_comb begin
    if (state == rrq_pkg::ST_IDLE) begin
      thr_ra = TW'(req.thread_id);
    end else if (state == rrq_pkg::ST_SCAN) begin
      thr_ra = TW'(slot_rd.thread);
    end else begin
      thr_ra = thr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrq_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = '0;
    slot_wa    = s2_idx;
    slot_wd    = '0;
    thr_wa     = thr_r;
    thr_wd     = '0;
    last_wa    = cpu_r;
    last_wd    = s2_idx;
    res_load   = 1'b0;
    res_next   = '0;
    unique case (state)
      rrq_pkg::ST_CLEAR: begin
        if (!clr_busy) begin
          state_next = rrq_pkg::ST_IDLE;
        end
      end
      rrq_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req_bad) begin
            res_load   = 1'b1;
            state_next = rrq_pkg::ST_DONE;
          end else begin
            state_next = rrq_pkg::ST_LOOKUP;
          end
        end
      end
      rrq_pkg::ST_LOOKUP: begin
        unique case (cmd_r)
          rrq_pkg::CMD_RELEASE: begin
            we.thr     = 1'b1;
            thr_wd     = '{enq: thr_rd.enq, locked: 1'b0};
            res_load   = 1'b1;
            state_next = rrq_pkg::ST_DONE;
          end
          rrq_pkg::CMD_DEQUEUE: begin
            if (!thr_rd.enq) begin
              res_load    = 1'b1;
              res_next.ok = 1'b1;
              state_next  = rrq_pkg::ST_DONE;
            end else begin
              state_next = rrq_pkg::ST_SCAN;
            end
          end
          default: state_next = rrq_pkg::ST_SCAN;
        endcase
      end
      rrq_pkg::ST_SCAN: begin
        if (hit) begin
          res_load      = 1'b1;
          res_next.ok   = 1'b1;
          res_next.slot = rrq_pkg::SLOT_OUT_W'(s2_idx);
          state_next    = rrq_pkg::ST_DONE;
          unique case (mode)
            rrq_pkg::MODE_FREE: begin
              we.slot = 1'b1;
              slot_wd = '{valid: 1'b1, thread: tid_r};
              we.thr  = 1'b1;
              thr_wd  = '{enq: 1'b1, locked: flags_r.locked};
            end
            rrq_pkg::MODE_FIND: begin
              if (cmd_r == rrq_pkg::CMD_DEQUEUE) begin
                we.slot = 1'b1;
                we.thr  = 1'b1;
                thr_wd  = '{enq: 1'b0, locked: flags_r.locked};
              end
            end
            rrq_pkg::MODE_PICK: begin
              we.thr          = 1'b1;
              thr_wa          = TW'(s2_ent.thread);
              thr_wd          = '{enq: thr_rd.enq, locked: 1'b1};
              we.last         = 1'b1;
              res_next.thread = s2_ent.thread;
            end
            default: res_next = '0;
          endcase
        end else if (s2_vld && s2_last) begin
          // no match fails; an enqueue of an enqueued thread is ok at slot zero
          res_load    = 1'b1;
          res_next.ok = (mode == rrq_pkg::MODE_FIND) && (cmd_r == rrq_pkg::CMD_ENQUEUE);
          state_next  = rrq_pkg::ST_DONE;
        end
      end
      rrq_pkg::ST_DONE: begin
        if (done_ack) begin
          state_next = rrq_pkg::ST_IDLE;
        end
      end
      default: state_next = rrq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // command capture and scan setup
  always_ff @(posedge clk) begin
    if (state == rrq_pkg::ST_IDLE && req.valid) begin
      cmd_r <= rrq_pkg::cmd_t'(req.cmd);
      tid_r <= req.thread_id;
      thr_r <= TW'(req.thread_id);
      cpu_r <= CW'(req.cpu_index);
    end
    if (state == rrq_pkg::ST_LOOKUP) begin
      flags_r <= thr_rd;
      unique case (cmd_r)
        rrq_pkg::CMD_PICK:    mode <= rrq_pkg::MODE_PICK;
        rrq_pkg::CMD_ENQUEUE: mode <= thr_rd.enq ? rrq_pkg::MODE_FIND : rrq_pkg::MODE_FREE;
        default:              mode <= rrq_pkg::MODE_FIND;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rrq_pkg::ST_LOOKUP) begin
      scan_idx <= (cmd_r == rrq_pkg::CMD_PICK) ? pick_start : '0;
    end else if (state == rrq_pkg::ST_SCAN && issue) begin
      scan_idx <= (scan_idx == SW'(SLOTS - 1)) ? '0 : scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
    end else if (state == rrq_pkg::ST_LOOKUP) begin
      issue_cnt <= '0;
    end else if (state == rrq_pkg::ST_SCAN && issue) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
  end

  // scan pipeline: slot read, then thread flag read, then compare
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (state == rrq_pkg::ST_SCAN && !scan_end) begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
    end else begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= scan_idx;
    s1_last <= (issue_cnt == CNTW'(SLOTS - 1));
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_ent  <= slot_rd;
  end

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req.ready)
    else $error("command taken during the clearing sweep");

  a_slot_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    we.slot |-> (state == rrq_pkg::ST_SCAN && mode != rrq_pkg::MODE_PICK))
    else $error("slot table written outside an enqueue or dequeue scan");

  a_last_write_on_pick: assert property (@(posedge clk) disable iff (rst)
    we.last |-> (mode == rrq_pkg::MODE_PICK && hit))
    else $error("last index written without a pick hit");

  a_issue_bounded: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= CNTW'(SLOTS))
    else $error("scan issued more reads than slots");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == rrq_pkg::ST_SCAN && s2_vld && s2_last) |=> (state == rrq_pkg::ST_DONE))
    else $error("scan did not finish after its last slot");
`endif

endmodule

/* rtl/core/round_robin_run_queue_unit.sv */
// round_robin_run_queue_unit: top level of the round-robin run queue
// holds the result register; instantiates rrq_mems and rrq_ctrl
// depends on rrq_pkg and rrq_ifs
`timescale 1ns / 1ps

// Run queue of SLOTS thread slots with per-thread enqueued and lock flags and a
// last-picked slot per cpu, all held in synchronous memories with one read and one
// write port each. Commands are handled one at a time. Release and a dequeue of a
// thread that is not enqueued finish after the flag lookup, with no scan; commands
// with a thread or cpu index out of range go straight to a failed result. Enqueue,
// dequeue and pick walk the slot table with a pipelined scan, one slot per cycle,
// and stop at the first match. The scan rate is set by the single read port of the
// slot memory. After reset a clearing sweep zeroes every entry of the three memories
// before the first command is taken. A finished result sits in an output register,
// so the next command is accepted while the previous result beat waits to be taken.
module round_robin_run_queue_unit #(
  parameter int SLOTS      = 64,
  parameter int THREAD_IDS = 256,
  parameter int CPUS       = 8
) (
  input logic       clk,
  input logic       rst,
  rrq_cmd_if.sink   req,
  rrq_res_if.source rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int TW = $clog2(THREAD_IDS);
  localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;

  logic               clr_busy;
  rrq_pkg::wr_en_t    we;
  logic [SW-1:0]      slot_wa;
  rrq_pkg::slot_ent_t slot_wd;
  logic [SW-1:0]      slot_ra;
  rrq_pkg::slot_ent_t slot_rd;
  logic [TW-1:0]      thr_wa;
  rrq_pkg::thr_ent_t  thr_wd;
  logic [TW-1:0]      thr_ra;
  rrq_pkg::thr_ent_t  thr_rd;
  logic [CW-1:0]      last_wa;
  logic [SW-1:0]      last_wd;
  logic [CW-1:0]      last_ra;
  logic [SW-1:0]      last_rd;
  logic               done_valid;
  logic               done_ack;
  rrq_pkg::result_t   res;

  logic               out_vld;
  rrq_pkg::result_t   out_res;

  rrq_mems #(
    .SLOTS      (SLOTS),
    .THREAD_IDS (THREAD_IDS),
    .CPUS       (CPUS)
  ) u_mems (
    .clk      (clk),
    .rst      (rst),
    .clr_busy (clr_busy),
    .we       (we),
    .slot_wa  (slot_wa),
    .slot_wd  (slot_wd),
    .slot_ra  (slot_ra),
    .slot_rd  (slot_rd),
    .thr_wa   (thr_wa),
    .thr_wd   (thr_wd),
    .thr_ra   (thr_ra),
    .thr_rd   (thr_rd),
    .last_wa  (last_wa),
    .last_wd  (last_wd),
    .last_ra  (last_ra),
    .last_rd  (last_rd)
  );

  rrq_ctrl #(
    .SLOTS      (SLOTS),
    .THREAD_IDS (THREAD_IDS),
    .CPUS       (CPUS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .clr_busy   (clr_busy),
    .we         (we),
    .slot_wa    (slot_wa),
    .slot_wd    (slot_wd),
    .slot_ra    (slot_ra),
    .slot_rd    (slot_rd),
    .thr_wa     (thr_wa),
    .thr_wd     (thr_wd),
    .thr_ra     (thr_ra),
    .thr_rd     (thr_rd),
    .last_wa    (last_wa),
    .last_wd    (last_wd),
    .last_ra    (last_ra),
    .last_rd    (last_rd),
    .done_valid (done_valid),
    .done_ack   (done_ack),
    .res        (res)
  );

  // result register, loads when empty or being drained this cycle
  assign done_ack = done_valid && (!out_vld || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (done_ack) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ack) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.ok            = out_res.ok;
  assign rsp.picked_thread = out_res.thread;
  assign rsp.picked_slot   = out_res.slot;

endmodule
